@@ design/lhd_pkg.sv @@
package lhd_pkg;

	// sizing of the point store
	localparam int MAX_POINTS  = 256;
	localparam int MAX_DIMS    = 16;
	localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int PT_W        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int SUM_W       = $clog2(STORE_DEPTH + 1);

	// field widths
	localparam int N_W     = 9;
	localparam int K_W     = 5;
	localparam int LVL_W   = 8;
	localparam int SHIFT_W = 8;
	localparam int MODE_W  = 2;
	localparam int VAL_W   = 9;
	localparam int DIST_W  = 13;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd3;

	// transform codes
	localparam logic [MODE_W-1:0] XFORM_NONE         = 2'd0;
	localparam logic [MODE_W-1:0] XFORM_WILLIAMS     = 2'd1;
	localparam logic [MODE_W-1:0] XFORM_MOD_WILLIAMS = 2'd2;

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [MODE_W-1:0] mode;
	} fold_cfg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FOLD,
		ST_PAIR,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

@@ design/lhd_fold.sv @@
module lhd_fold (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [lhd_pkg::VAL_W-1:0] sum,
	input  lhd_pkg::fold_cfg_t      cfg,
	output logic                    done,
	output logic [lhd_pkg::VAL_W-1:0] value
);
	import lhd_pkg::*;

	localparam int STEP_W = $clog2(VAL_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W - 1);

	logic              busy_q;
	logic              fin_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VAL_W-1:0]  num_q;
	logic [VAL_W-1:0]  rem_q;

	logic [VAL_W:0]    trial;
	logic [VAL_W:0]    diff_w;
	logic [VAL_W-1:0]  rem_nxt;

	logic [VAL_W:0]    n_p1;
	logic [VAL_W-1:0]  half;
	logic [VAL_W-1:0]  rv;
	logic [VAL_W:0]    dbl;
	logic [VAL_W:0]    ref2;
	logic [VAL_W:0]    ref2_m1;

	// restoring remainder, one quotient bit per cycle
	assign trial   = {rem_q, num_q[VAL_W-1]};
	assign diff_w  = trial - {1'b0, cfg.n};
	assign rem_nxt = (trial >= {1'b0, cfg.n}) ? diff_w[VAL_W-1:0] : trial[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= busy_q && !start && (cnt_q == STEP_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= sum;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[VAL_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	// fold of the reduced level
	assign n_p1    = {1'b0, cfg.n} + 1'b1;
	assign half    = n_p1[VAL_W:1];
	assign rv      = cfg.n - rem_q;
	assign dbl     = {rem_q, 1'b0};
	assign ref2    = {rv, 1'b0};
	assign ref2_m1 = ref2 - 1'b1;

	always_comb begin
		case (cfg.mode)
			XFORM_WILLIAMS:     value = (rem_q < half) ? dbl[VAL_W-1:0] : ref2_m1[VAL_W-1:0];
			XFORM_MOD_WILLIAMS: value = (rem_q < half) ? dbl[VAL_W-1:0] : ref2[VAL_W-1:0];
			default:            value = rem_q;
		endcase
	end

	assign done = fin_q;

endmodule

@@ design/lhd_min_l1_distance.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------
// in       | in_valid / in_stall      | level (8b), row-major order
// out      | out_valid / out_stall    | min_distance (13b), one per design
// cfg      | cfg_we, cfg_index        | cfg_data (9b), no read-back
//
// each level in turn: accept, bit-serial remainder of level plus shift, store write
// after the last level is stored: K*N*(N-1)/2 coordinate pairs are scanned, one per cycle
// through both store read ports, then a drain and a result load that waits while a result is stalled
// reset clears control state and the running minimum; the point store is never cleared, every
// entry read belongs to the current design
// results wait in an output register; a new design loads while a result is stalled
module lhd_min_l1_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lhd_pkg::LVL_W-1:0]     level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lhd_pkg::DIST_W-1:0]    min_distance,
	input  logic                        cfg_we,
	input  logic [lhd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lhd_pkg::CFG_W-1:0]     cfg_data
);
	import lhd_pkg::*;

	state_t state_q, state_d;

	logic [N_W-1:0]     num_points_q;
	logic [K_W-1:0]     num_dims_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [MODE_W-1:0]  transform_mode_q;

	logic [N_W-1:0]     n_eff;
	logic [K_W-1:0]     k_eff;
	logic [CNT_W-1:0]   total;
	logic [CNT_W-1:0]   load_next;
	logic               last_level;
	logic [PT_W-1:0]    i_last;
	logic [PT_W-1:0]    j_last;
	logic [DIM_W-1:0]   o_last;
	logic [ADDR_W-1:0]  k_a;

	logic [CNT_W-1:0]   load_count_q;
	logic               in_acc;
	logic               out_free;

	fold_cfg_t          fold_cfg;
	logic [VAL_W-1:0]   fold_sum;
	logic               fold_done;
	logic [VAL_W-1:0]   fold_value;

	logic [PT_W-1:0]    pi_q, pj_q;
	logic [DIM_W-1:0]   po_q;
	logic [ADDR_W-1:0]  base_i_q, base_j_q;
	logic [ADDR_W-1:0]  addr_a, addr_b;
	logic               issue;
	logic               o_end, j_end, pair_end;
	logic               pair_start;

	logic [VAL_W-1:0]   store_mem [STORE_DEPTH];
	logic [VAL_W-1:0]   rd_a_s1, rd_b_s1;
	logic               vld_s1, first_s1, last_s1, end_s1;

	logic [VAL_W-1:0]   diff;
	logic [SUM_W-1:0]   sum_q, sum_nxt;
	logic [DIST_W-1:0]  cand;
	logic [DIST_W-1:0]  best_q;

	logic               out_valid_q;
	logic [DIST_W-1:0]  min_distance_q;

	// effective configuration
	always_comb begin
		if (num_points_q == '0)
			n_eff = N_W'(1);
		else if (int'(num_points_q) > MAX_POINTS)
			n_eff = N_W'(MAX_POINTS);
		else
			n_eff = num_points_q;
		if (num_dims_q == '0)
			k_eff = K_W'(1);
		else if (int'(num_dims_q) > MAX_DIMS)
			k_eff = K_W'(MAX_DIMS);
		else
			k_eff = num_dims_q;
	end

	assign total      = CNT_W'(n_eff) * CNT_W'(k_eff);
	assign load_next  = load_count_q + 1'b1;
	assign last_level = (load_next == total);
	assign i_last     = PT_W'(n_eff - N_W'(2));
	assign j_last     = PT_W'(n_eff - N_W'(1));
	assign o_last     = DIM_W'(k_eff - K_W'(1));
	assign k_a        = ADDR_W'(k_eff);

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q     <= N_W'(256);
			num_dims_q       <= K_W'(16);
			shift_q          <= '0;
			transform_mode_q <= XFORM_NONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_POINTS:     num_points_q     <= cfg_data[N_W-1:0];
				REG_NUM_DIMS:       num_dims_q       <= cfg_data[K_W-1:0];
				REG_SHIFT:          shift_q          <= cfg_data[SHIFT_W-1:0];
				REG_TRANSFORM_MODE: transform_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign fold_cfg.n    = n_eff;
	assign fold_cfg.mode = transform_mode_q;
	assign fold_sum      = {1'b0, level} + {1'b0, shift_q};

	lhd_fold u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.sum    (fold_sum),
		.cfg    (fold_cfg),
		.done   (fold_done),
		.value  (fold_value)
	);

	// pair scan control
	assign o_end      = (po_q == o_last);
	assign j_end      = (pj_q == j_last);
	assign pair_end   = (pi_q == i_last) && j_end && o_end;
	assign pair_start = (state_q == ST_FOLD) && fold_done && last_level;
	assign addr_a     = base_i_q + ADDR_W'(po_q);
	assign addr_b     = base_j_q + ADDR_W'(po_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (fold_done) begin
					if (!last_level)
						state_d = ST_LOAD;
					else if (n_eff == N_W'(1))
						state_d = ST_DONE;
					else
						state_d = ST_PAIR;
				end
			end
			ST_PAIR: begin
				issue = 1'b1;
				if (pair_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (end_s1)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			load_count_q <= '0;
		else if (cfg_we)
			load_count_q <= '0;
		else if (state_q == ST_FOLD && fold_done)
			load_count_q <= last_level ? '0 : load_next;
	end

	always_ff @(posedge clk) begin
		if (pair_start) begin
			pi_q     <= '0;
			pj_q     <= PT_W'(1);
			po_q     <= '0;
			base_i_q <= '0;
			base_j_q <= k_a;
		end else if (issue) begin
			if (o_end) begin
				po_q <= '0;
				if (j_end) begin
					pi_q     <= pi_q + 1'b1;
					pj_q     <= pi_q + PT_W'(2);
					base_i_q <= base_i_q + k_a;
					base_j_q <= base_i_q + {k_a[ADDR_W-2:0], 1'b0};
				end else begin
					pj_q     <= pj_q + 1'b1;
					base_j_q <= base_j_q + k_a;
				end
			end else begin
				po_q <= po_q + 1'b1;
			end
		end
	end

	// point store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (state_q == ST_FOLD && fold_done)
			store_mem[load_count_q[ADDR_W-1:0]] <= fold_value;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_a_s1 <= store_mem[addr_a];
			rd_b_s1 <= store_mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			end_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			end_s1 <= issue && pair_end;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (po_q == '0);
		last_s1  <= o_end;
	end

	// distance accumulate and running minimum
	assign diff    = (rd_a_s1 > rd_b_s1) ? rd_a_s1 - rd_b_s1 : rd_b_s1 - rd_a_s1;
	assign sum_nxt = (first_s1 ? SUM_W'(0) : sum_q) + SUM_W'(diff);
	assign cand    = (int'(sum_nxt) < int'(DIST_MAX)) ? DIST_W'(sum_nxt) : DIST_MAX;

	always_ff @(posedge clk) begin
		if (vld_s1)
			sum_q <= sum_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			best_q <= DIST_MAX;
		else if (pair_start)
			best_q <= (n_eff == N_W'(1)) ? '0 : DIST_MAX;
		else if (vld_s1 && last_s1 && cand < best_q)
			best_q <= cand;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free)
			min_distance_q <= best_q;
	end

	assign out_valid    = out_valid_q;
	assign min_distance = min_distance_q;

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_PAIR || state_q == ST_DRAIN))
		else $error("store read data outside the pair scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q < total)
		else $error("load count reached the design size");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR |-> pj_q > pi_q)
		else $error("pair scan visits a pair out of order");

	a_fold_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		fold_done |-> state_q == ST_FOLD)
		else $error("fold finished outside the fold wait");

endmodule
